[sv/bwdr_pkg.sv]
// Shared types, constants and lookup functions for the body-to-world dead reckoning block.
package bwdr_pkg;

  // Field widths.
  localparam int YAW_W  = 17;
  localparam int VEL_W  = 16;
  localparam int WVEL_W = 17;
  localparam int HEAD_W = 16;
  localparam int POS_W  = 32;
  localparam int ACC_W  = 48;
  localparam int PER_W  = 16;
  localparam int HGT_W  = 16;
  localparam int T_W    = 18;

  // Default fraction bits of the rotator vector.
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // Rotator sizing; the angle register holds degrees * 100 * 2^16.
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int ZW           = HEAD_W + 16;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  // Angles in hundredths of a degree.
  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;

  localparam logic [PER_W-1:0] PERIOD_RST = 16'd655;

  // Control from the sequencer to the rotator.
  typedef struct packed {
    logic start;
    logic flip;
  } cordic_ctrl_t;

  // Top-level sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WRAP = 5'b00010,
    ST_ROT  = 5'b00100,
    ST_MAC  = 5'b01000,
    ST_HOLD = 5'b10000
  } state_t;

  // Passes of the shared multiplier.
  typedef enum logic [2:0] {
    MS_VX_C,
    MS_VY_S,
    MS_VX_S,
    MS_VY_C,
    MS_ACC_Y,
    MS_POS_X,
    MS_WY_P,
    MS_POS_Y
  } mac_step_t;

  // Arctangent of 2^-i in hundredths of a degree times 2^16.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:    r = 32'sd294912000;
      5'd1:    r = 32'sd174096719;
      5'd2:    r = 32'sd91987925;
      5'd3:    r = 32'sd46694507;
      5'd4:    r = 32'sd23437865;
      5'd5:    r = 32'sd11730358;
      5'd6:    r = 32'sd5866610;
      5'd7:    r = 32'sd2933485;
      5'd8:    r = 32'sd1466764;
      5'd9:    r = 32'sd733385;
      5'd10:   r = 32'sd366693;
      5'd11:   r = 32'sd183346;
      5'd12:   r = 32'sd91673;
      5'd13:   r = 32'sd45837;
      5'd14:   r = 32'sd22918;
      5'd15:   r = 32'sd11459;
      5'd16:   r = 32'sd5730;
      5'd17:   r = 32'sd2865;
      5'd18:   r = 32'sd1432;
      5'd19:   r = 32'sd716;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Starting X of the rotator: the inverse gain rounded to the given fraction bits.
  function automatic longint cordic_x0(input int frac);
    longint one;
    one = 64'sd1;
    return (CORDIC_GAIN_Q30 + (one << (29 - frac))) >>> (30 - frac);
  endfunction

endpackage

[sv/bwdr_cordic.sv]
// Iterative CORDIC rotator producing cosine and sine of the folded heading.
module bwdr_cordic #(
  parameter int ANGLE_FRAC_BITS = bwdr_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int XW              = ANGLE_FRAC_BITS + 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bwdr_pkg::cordic_ctrl_t      ctrl,
  input  logic signed [bwdr_pkg::HEAD_W-1:0] angle,
  output logic                        done,
  output logic signed [XW-1:0]        cos_out,
  output logic signed [XW-1:0]        sin_out
);
  import bwdr_pkg::*;

  localparam logic signed [XW-1:0] X_INIT = XW'(cordic_x0(ANGLE_FRAC_BITS));

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [STEP_W-1:0]    step;
  logic                 busy;
  logic                 flip;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  // One micro-rotation per cycle: shifted copies of the other coordinate.
  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && (step == STEP_W'(CORDIC_STEPS - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Vector and residual angle registers.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x    <= X_INIT;
      y    <= '0;
      z    <= {angle, 16'd0};
      step <= '0;
      flip <= ctrl.flip;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_lut(step);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_lut(step);
      end
      step <= step + STEP_W'(1);
    end
  end

  // A heading beyond a right angle was rotated half a turn; undo it by negation.
  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule

[sv/body_to_world_dead_reckoning_core.sv]
// Top level: heading wrap, CORDIC rotation, shared multiplier and position integration.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | yaw_angle, body_vel_x/y/z, height_cm
//  out     | out_valid / out_ready| world_vel_x/y/z, world_pos_x/y/z, heading_offset
//  cfg     | cfg_wr_en            | cfg_wr_data (sample period)
//
// One sample goes through heading wrap, 20 CORDIC iterations plus a handoff, 8 passes
// through the one shared multiplier and a load of the output register. in_ready is
// high only when the sequencer idles. A finished result waits in the output register,
// so the next sample is taken while out_ready is low. Synchronous reset clears the
// position accumulators and sets the sample period to 655.
module body_to_world_dead_reckoning_core #(
  parameter int ANGLE_FRAC_BITS = bwdr_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bwdr_pkg::YAW_W-1:0]   yaw_angle,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_x,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_y,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_z,
  input  logic        [bwdr_pkg::HGT_W-1:0]   height_cm,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bwdr_pkg::WVEL_W-1:0]  world_vel_x,
  output logic signed [bwdr_pkg::WVEL_W-1:0]  world_vel_y,
  output logic signed [bwdr_pkg::VEL_W-1:0]   world_vel_z,
  output logic signed [bwdr_pkg::POS_W-1:0]   world_pos_x,
  output logic signed [bwdr_pkg::POS_W-1:0]   world_pos_y,
  output logic        [bwdr_pkg::HGT_W-1:0]   world_pos_z,
  output logic signed [bwdr_pkg::HEAD_W-1:0]  heading_offset,
  input  logic                                cfg_wr_en,
  input  logic        [bwdr_pkg::PER_W-1:0]   cfg_wr_data
);
  import bwdr_pkg::*;

  localparam int XW = ANGLE_FRAC_BITS + 3;
  localparam int BW = (XW > PER_W + 1) ? XW : PER_W + 1;
  localparam int PW = WVEL_W + BW;
  localparam int AW = PW + 1;

  localparam logic signed [T_W-1:0]    TURN_T    = T_W'(FULL_TURN);
  localparam logic signed [T_W-1:0]    HALF_T    = T_W'(HALF_TURN);
  localparam logic signed [T_W-1:0]    QUARTER_T = T_W'(QUARTER_TURN);
  localparam logic signed [HEAD_W-1:0] HALF_H    = HEAD_W'(HALF_TURN);
  localparam logic signed [HEAD_W-1:0] QUARTER_H = HEAD_W'(QUARTER_TURN);

  localparam logic signed [AW-1:0] RND_HALF = AW'(longint'(1) << (ANGLE_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] WV_MAX   = AW'(65535);
  localparam logic signed [AW-1:0] WV_MIN   = -AW'(65536);

  localparam logic signed [ACC_W-1:0] P32_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] P32_MIN = -ACC_W'(64'sd2147483648);

  state_t    state;
  mac_step_t step;

  logic signed [T_W-1:0]    t;
  logic signed [HEAD_W-1:0] head;
  logic signed [VEL_W-1:0]  vx;
  logic signed [VEL_W-1:0]  vy;
  logic signed [VEL_W-1:0]  vz;
  logic        [HGT_W-1:0]  hgt;
  logic        [PER_W-1:0]  period;

  logic signed [PW-1:0]     prod;
  logic signed [AW-1:0]     acc;
  logic signed [WVEL_W-1:0] wx;
  logic signed [WVEL_W-1:0] wy;
  logic signed [ACC_W-1:0]  pos_x;
  logic signed [ACC_W-1:0]  pos_y;

  logic signed [XW-1:0]     cos_v;
  logic signed [XW-1:0]     sin_v;
  logic                     rot_done;
  cordic_ctrl_t             cctrl;

  logic signed [T_W-1:0]    head_full;
  logic signed [HEAD_W-1:0] head_w;
  logic signed [HEAD_W-1:0] cdeg;
  logic                     wrap_done;

  logic signed [WVEL_W-1:0] op_a;
  logic signed [BW-1:0]     op_b;
  logic signed [AW-1:0]     prod_ext;
  logic signed [AW-1:0]     rsum;
  logic signed [AW-1:0]     rq;
  logic signed [WVEL_W-1:0] wv_sat;
  logic signed [ACC_W:0]    psum;
  logic signed [ACC_W-1:0]  pos_sel;
  logic signed [ACC_W-1:0]  pos_sat;
  logic                     load_out;

  assign in_ready = (state == ST_IDLE);

  // Heading and fold into the half plane the rotator covers.
  assign wrap_done = (state == ST_WRAP) && (t >= 0) && (t < TURN_T);
  assign head_full = t - HALF_T;
  assign head_w    = head_full[HEAD_W-1:0];

  always_comb begin
    cctrl.start = wrap_done;
    cctrl.flip  = 1'b0;
    cdeg        = head_w;
    if (head_w > QUARTER_H) begin
      cdeg       = head_w - HALF_H;
      cctrl.flip = 1'b1;
    end else if (head_w < -QUARTER_H) begin
      cdeg       = head_w + HALF_H;
      cctrl.flip = 1'b1;
    end
  end

  bwdr_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .XW              (XW)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cctrl),
    .angle   (cdeg),
    .done    (rot_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      MS_VX_C: begin
        op_a = WVEL_W'(vx);
        op_b = BW'(cos_v);
      end
      MS_VY_S: begin
        op_a = WVEL_W'(vy);
        op_b = BW'(sin_v);
      end
      MS_VX_S: begin
        op_a = WVEL_W'(vx);
        op_b = BW'(sin_v);
      end
      MS_VY_C: begin
        op_a = WVEL_W'(vy);
        op_b = BW'(cos_v);
      end
      MS_ACC_Y: begin
        op_a = wx;
        op_b = BW'(period);
      end
      MS_WY_P: begin
        op_a = wy;
        op_b = BW'(period);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Round half up to whole cm/s and saturate to the output width.
  assign prod_ext = AW'(prod);
  assign rsum     = acc + RND_HALF;
  assign rq       = rsum >>> ANGLE_FRAC_BITS;

  always_comb begin
    if (rq > WV_MAX) begin
      wv_sat = WVEL_W'(WV_MAX);
    end else if (rq < WV_MIN) begin
      wv_sat = WVEL_W'(WV_MIN);
    end else begin
      wv_sat = rq[WVEL_W-1:0];
    end
  end

  // Saturating add of the period product into the selected accumulator.
  assign pos_sel = (step == MS_POS_X) ? pos_x : pos_y;
  assign psum    = {pos_sel[ACC_W-1], pos_sel} + (ACC_W+1)'(prod);

  always_comb begin
    if (psum[ACC_W] != psum[ACC_W-1]) begin
      pos_sat = psum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      pos_sat = psum[ACC_W-1:0];
    end
  end

  // Position output in 1/256 cm, clamped to 32 bits.
  function automatic logic signed [POS_W-1:0] pos_out(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] sh;
    logic signed [POS_W-1:0] r;
    sh = p >>> 8;
    if (sh > P32_MAX) begin
      r = POS_W'(P32_MAX);
    end else if (sh < P32_MIN) begin
      r = POS_W'(P32_MIN);
    end else begin
      r = sh[POS_W-1:0];
    end
    return r;
  endfunction

  assign load_out = (state == ST_HOLD) && (!out_valid || out_ready);

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= MS_VX_C;
      period <= PERIOD_RST;
      pos_x  <= '0;
      pos_y  <= '0;
    end else begin
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (wrap_done) begin
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (rot_done) begin
            state <= ST_MAC;
            step  <= MS_VX_C;
          end
        end
        ST_MAC: begin
          step <= mac_step_t'(step + 3'd1);
          if (step == MS_POS_X) begin
            pos_x <= pos_sat;
          end
          if (step == MS_POS_Y) begin
            pos_y <= pos_sat;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample capture and heading wrap, one correction per cycle.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      t   <= {yaw_angle[YAW_W-1], yaw_angle} + QUARTER_T;
      vx  <= body_vel_x;
      vy  <= body_vel_y;
      vz  <= body_vel_z;
      hgt <= height_cm;
    end else if (state == ST_WRAP) begin
      if (t < 0) begin
        t <= t + TURN_T;
      end else if (t >= TURN_T) begin
        t <= t - TURN_T;
      end else begin
        head <= head_w;
      end
    end
  end

  // Multiplier pipeline register and rotation sums.
  always_ff @(posedge clk) begin
    if (state == ST_MAC) begin
      prod <= op_a * op_b;
      case (step)
        MS_VY_S:  acc <= prod_ext;
        MS_VX_S:  acc <= acc + prod_ext;
        MS_VY_C: begin
          wx  <= wv_sat;
          acc <= -prod_ext;
        end
        MS_ACC_Y: acc <= acc + prod_ext;
        MS_POS_X: wy  <= wv_sat;
        default:  acc <= acc;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      world_vel_x    <= wx;
      world_vel_y    <= wy;
      world_vel_z    <= vz;
      world_pos_x    <= pos_out(pos_x);
      world_pos_y    <= pos_out(pos_y);
      world_pos_z    <= hgt;
      heading_offset <= head;
    end
  end

endmodule

[sv/bwdr_checker.sv]
// Port-level checker for the dead reckoning core, bound to the top level.
module bwdr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [bwdr_pkg::YAW_W-1:0]   yaw_angle,
  input logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_x,
  input logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_y,
  input logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_z,
  input logic        [bwdr_pkg::HGT_W-1:0]   height_cm,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bwdr_pkg::WVEL_W-1:0]  world_vel_x,
  input logic signed [bwdr_pkg::WVEL_W-1:0]  world_vel_y,
  input logic signed [bwdr_pkg::VEL_W-1:0]   world_vel_z,
  input logic signed [bwdr_pkg::POS_W-1:0]   world_pos_x,
  input logic signed [bwdr_pkg::POS_W-1:0]   world_pos_y,
  input logic        [bwdr_pkg::HGT_W-1:0]   world_pos_z,
  input logic signed [bwdr_pkg::HEAD_W-1:0]  heading_offset,
  input logic                                cfg_wr_en,
  input logic        [bwdr_pkg::PER_W-1:0]   cfg_wr_data
);

  // After reset the block is empty and ready for a transfer.
  a_reset_state: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not idle and empty after reset");

  // A transfer in makes the block busy, so in_ready goes low.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon after a transfer");

  // A taken sample does not make out_valid rise at once.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared before the rotation could finish");

  // A stalled result stays valid and keeps its positions and heading.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(world_pos_x) && $stable(world_pos_y) &&
       $stable(heading_offset)))
    else $error("stalled result changed");

endmodule

bind body_to_world_dead_reckoning_core bwdr_checker u_bwdr_checker (.*);

[tb/dead_reckoning_checker.sv]
// Checker that predicts every dead reckoning result and compares it with the output transfers.
module dead_reckoning_checker #(
  parameter int FRAC = bwdr_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [bwdr_pkg::YAW_W-1:0]   yaw_angle,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_x,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_y,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   body_vel_z,
  input  logic        [bwdr_pkg::HGT_W-1:0]   height_cm,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [bwdr_pkg::WVEL_W-1:0]  world_vel_x,
  input  logic signed [bwdr_pkg::WVEL_W-1:0]  world_vel_y,
  input  logic signed [bwdr_pkg::VEL_W-1:0]   world_vel_z,
  input  logic signed [bwdr_pkg::POS_W-1:0]   world_pos_x,
  input  logic signed [bwdr_pkg::POS_W-1:0]   world_pos_y,
  input  logic        [bwdr_pkg::HGT_W-1:0]   world_pos_z,
  input  logic signed [bwdr_pkg::HEAD_W-1:0]  heading_offset,
  input  logic                                cfg_wr_en,
  input  logic        [bwdr_pkg::PER_W-1:0]   cfg_wr_data,
  output int                                  mismatch_count,
  output int                                  results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import bwdr_pkg::*;

  // Rotator start vector: the inverse CORDIC gain rounded to FRAC fraction bits.
  localparam longint ROT_X0 =
    (CORDIC_GAIN_Q30 + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
  localparam longint ROUND_HALF = longint'(1) <<< (FRAC - 1);
  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));
  localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));
  localparam longint WVEL_HI = (longint'(1) <<< (WVEL_W - 1)) - 1;
  localparam longint WVEL_LO = -(longint'(1) <<< (WVEL_W - 1));

  typedef struct packed {
    logic signed [WVEL_W-1:0] vel_x;
    logic signed [WVEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0]  vel_z;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic        [HGT_W-1:0]  pos_z;
    logic signed [HEAD_W-1:0] heading;
  } nav_result_t;

  // Rotation angle of each CORDIC step in 0.01 degree * 2^16.
  longint atan_step [0:CORDIC_STEPS-1] = '{
    294912000, 174096719, 91987925, 46694507, 23437865,
    11730358, 5866610, 2933485, 1466764, 733385,
    366693, 183346, 91673, 45837, 22918,
    11459, 5730, 2865, 1432, 716
  };

  logic [PER_W-1:0] period_q;
  longint           acc_x;
  longint           acc_y;
  nav_result_t      pending_nav_results[$];
  nav_result_t      oldest;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Wraps the heading, rotates the body velocity and advances both position sums.
  function automatic nav_result_t dead_reckon_step(
    input logic signed [YAW_W-1:0] yaw,
    input logic signed [VEL_W-1:0] vx_in,
    input logic signed [VEL_W-1:0] vy_in,
    input logic signed [VEL_W-1:0] vz_in,
    input logic        [HGT_W-1:0] hgt
  );
    nav_result_t r;
    longint vx, vy, m, head, ang, x, y, z, dx, dy, c, s, wx, wy;
    bit flip;
    vx = vx_in;
    vy = vy_in;

    // Heading is yaw minus a quarter turn, wrapped into [-180, 180) degrees.
    m = (longint'(yaw) + QUARTER_TURN) % FULL_TURN;
    if (m < 0) m += FULL_TURN;
    head = m - HALF_TURN;

    // Beyond a quarter turn the rotator works half a turn away and negates its result.
    ang = head;
    flip = 1'b0;
    if (ang > QUARTER_TURN) begin
      ang -= HALF_TURN;
      flip = 1'b1;
    end else if (ang < -QUARTER_TURN) begin
      ang += HALF_TURN;
      flip = 1'b1;
    end

    x = ROT_X0;
    y = 0;
    z = ang * 65536;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_step[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;

    wx = clip((vx * c + vy * s + ROUND_HALF) >>> FRAC, WVEL_LO, WVEL_HI);
    wy = clip((vy * c - vx * s + ROUND_HALF) >>> FRAC, WVEL_LO, WVEL_HI);

    acc_x = clip(acc_x + wx * longint'(period_q), ACC_LO, ACC_HI);
    acc_y = clip(acc_y + wy * longint'(period_q), ACC_LO, ACC_HI);

    r.vel_x   = wx[WVEL_W-1:0];
    r.vel_y   = wy[WVEL_W-1:0];
    r.vel_z   = vz_in;
    r.pos_x   = POS_W'(clip(acc_x >>> 8, POS_LO, POS_HI));
    r.pos_y   = POS_W'(clip(acc_y >>> 8, POS_LO, POS_HI));
    r.pos_z   = hgt;
    r.heading = head[HEAD_W-1:0];
    return r;
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
    mismatch_count++;
  endtask

  // Track the configuration, queue a prediction per input transfer, check each output.
  always @(posedge clk) begin
    if (rst) begin
      period_q = PERIOD_RST;
      acc_x = 0;
      acc_y = 0;
      pending_nav_results.delete();
    end else begin
      if (cfg_wr_en) period_q = cfg_wr_data;

      if (out_valid && out_ready) begin
        if (pending_nav_results.size() == 0) begin
          $error("output transfer with no sample outstanding");
          mismatch_count++;
        end else begin
          oldest = pending_nav_results.pop_front();
          if (world_vel_x !== oldest.vel_x)
            flag_field("world_vel_x", oldest.vel_x, world_vel_x);
          if (world_vel_y !== oldest.vel_y)
            flag_field("world_vel_y", oldest.vel_y, world_vel_y);
          if (world_vel_z !== oldest.vel_z)
            flag_field("world_vel_z", oldest.vel_z, world_vel_z);
          if (world_pos_x !== oldest.pos_x)
            flag_field("world_pos_x", oldest.pos_x, world_pos_x);
          if (world_pos_y !== oldest.pos_y)
            flag_field("world_pos_y", oldest.pos_y, world_pos_y);
          if (world_pos_z !== oldest.pos_z)
            flag_field("world_pos_z", oldest.pos_z, world_pos_z);
          if (heading_offset !== oldest.heading)
            flag_field("heading_offset", oldest.heading, heading_offset);
        end
      end

      if (in_valid && in_ready)
        pending_nav_results.push_back(dead_reckon_step(yaw_angle, body_vel_x, body_vel_y,
                                                       body_vel_z, height_cm));
    end
    results_owed <= pending_nav_results.size();
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, sample stimulus, output pacing, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bwdr_pkg::*;

  // No transfer for this long means the block has hung.
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_PAUSE = 40;

  typedef enum int {RX_STREAM, RX_COIN, RX_BURSTY} rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [YAW_W-1:0]  yaw_angle = '0;
  logic signed [VEL_W-1:0]  body_vel_x = '0;
  logic signed [VEL_W-1:0]  body_vel_y = '0;
  logic signed [VEL_W-1:0]  body_vel_z = '0;
  logic        [HGT_W-1:0]  height_cm = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WVEL_W-1:0] world_vel_x;
  logic signed [WVEL_W-1:0] world_vel_y;
  logic signed [VEL_W-1:0]  world_vel_z;
  logic signed [POS_W-1:0]  world_pos_x;
  logic signed [POS_W-1:0]  world_pos_y;
  logic        [HGT_W-1:0]  world_pos_z;
  logic signed [HEAD_W-1:0] heading_offset;
  logic                     cfg_wr_en = 1'b0;
  logic        [PER_W-1:0]  cfg_wr_data = '0;

  int       mismatch_count;
  int       results_owed;
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       mode_left = 0;
  int       stall_left = 0;
  rx_mode_t rx_mode = RX_STREAM;

  body_to_world_dead_reckoning_core dut (.*);

  dead_reckoning_checker checker_i (.*);

  always #5 clk = ~clk;

  // Receiver: switches between streaming, coin-flip acceptance and long stalls.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(40, 400);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 60);
          out_ready <= (stall_left == 0);
        end
      endcase
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one sample and returns at the edge of its transfer; gaps fall between bursts.
  // Each field keeps the low bits of its argument.
  task automatic send_sample(input int yaw,
                             input int vx,
                             input int vy,
                             input int vz,
                             input int hgt);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    yaw_angle  <= YAW_W'(yaw);
    body_vel_x <= VEL_W'(vx);
    body_vel_y <= VEL_W'(vy);
    body_vel_z <= VEL_W'(vz);
    height_cm  <= HGT_W'(hgt);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic int any_velocity();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Random yaw: mostly in range, some near quarter-turn boundaries, some over all 17 bits.
  task automatic send_random_sample();
    int yaw;
    case ($urandom_range(0, 5))
      0:       yaw = $urandom();
      1:       yaw = QUARTER_TURN * (int'($urandom_range(0, 8)) - 4)
                     + int'($urandom_range(0, 4)) - 2;
      default: yaw = int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
    endcase
    send_sample(yaw, any_velocity(), any_velocity(), any_velocity(),
                $urandom_range(0, 65535));
  endtask

  // A straight run at near full speed at a 45 degree yaw, to push a position to its limit.
  task automatic drive_leg(input int count, input bit vx_neg, input bit vy_neg);
    int yaw;
    int jx;
    int jy;
    repeat (count) begin
      yaw = QUARTER_TURN / 2 + FULL_TURN * (int'($urandom_range(0, 2)) - 1)
            + int'($urandom_range(0, 100)) - 50;
      jx = $urandom_range(0, 300);
      jy = $urandom_range(0, 300);
      send_sample(yaw, vx_neg ? -32768 + jx : 32767 - jx, vy_neg ? -32768 + jy : 32767 - jy,
                  any_velocity(), $urandom_range(0, 65535));
    end
  endtask

  task automatic wait_for_results();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // The period register is only written once the block has gone idle.
  task automatic load_period(input logic [PER_W-1:0] value);
    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset period: heading wrap edges and field extremes.
    send_sample(QUARTER_TURN, 32767, 0, 0, 0);
    send_sample(0, 1000, -1000, 1, 1);
    send_sample(HALF_TURN, -32768, 32767, -1, 100);
    send_sample(HALF_TURN + 1, 32767, 32767, 32767, 65535);
    send_sample(-1, -32768, -32768, -32768, 0);
    send_sample(3 * QUARTER_TURN, 20000, -20000, 0, 500);
    send_sample(3 * QUARTER_TURN - 1, -20000, 20000, 5, 5);
    send_sample(-3 * QUARTER_TURN, 15000, 15000, 7, 7);
    send_sample(-FULL_TURN, 32767, -32768, 100, 1234);
    send_sample(FULL_TURN, -32768, 32767, -100, 4321);
    send_sample(65535, 25000, 5000, 32767, 65535);
    send_sample(-65536, -5000, -25000, -32768, 0);
    send_sample(QUARTER_TURN / 2, 32767, 32767, 0, 0);
    send_sample(QUARTER_TURN / 2, -32768, 32767, 0, 0);
    send_sample(20000, 12345, -23456, 3, 3);
    send_sample(-2000, -31000, 29000, -3, 3);
    send_sample(0, 0, 0, 0, 0);

    // A zero period must leave both positions frozen.
    load_period('0);
    repeat (30) send_random_sample();

    // Largest period: drive Y to its negative limit, then X to its negative limit.
    load_period('1);
    drive_leg(200, 1'b1, 1'b1);
    drive_leg(200, 1'b1, 1'b0);

    load_period(16'd1);
    repeat (120) send_random_sample();

    repeat (3) begin
      load_period(16'($urandom_range(2, 65534)));
      repeat (130) send_random_sample();
    end

    load_period('1);
    repeat (130) send_random_sample();

    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
